FILE: rtl/core/tsp_pkg.sv
package tsp_pkg;

   localparam int STEP_MAX = 4095;
   localparam int REV_MAX = 4096;
   localparam int Q_SHIFT = 19;

   localparam logic [1:0] LIGHT_LOW = 2'd0;
   localparam logic [1:0] LIGHT_UNBAL = 2'd1;
   localparam logic [1:0] LIGHT_BAL = 2'd2;

   localparam logic [2:0] REG_GAIN_PROP = 3'd0;
   localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
   localparam logic [2:0] REG_GAIN_DERIV = 3'd2;
   localparam logic [2:0] REG_DEADBAND = 3'd3;
   localparam logic [2:0] REG_LOW_LIGHT = 3'd4;
   localparam logic [2:0] REG_BAL_LIMIT = 3'd5;
   localparam logic [2:0] REG_AZ_REV = 3'd6;
   localparam logic [2:0] REG_ALT_LIMIT = 3'd7;

   localparam logic [15:0] RST_GAIN_PROP = 16'd24904;
   localparam logic [15:0] RST_GAIN_INTEG = 16'd983;
   localparam logic [15:0] RST_GAIN_DERIV = 16'd5243;
   localparam logic [9:0] RST_DEADBAND = 10'd2;
   localparam logic [11:0] RST_LOW_LIGHT = 12'd1800;
   localparam logic [10:0] RST_BAL_LIMIT = 11'd100;
   localparam logic [12:0] RST_AZ_REV = 13'd200;
   localparam logic [11:0] RST_ALT_LIMIT = 12'd90;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_POS,
      ST_POSW,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [15:0] gain_prop;
      logic [15:0] gain_integ;
      logic [15:0] gain_deriv;
      logic [9:0] error_deadband;
      logic [11:0] low_light_level;
      logic [10:0] balance_limit;
      logic [12:0] az_steps_rev;
      logic [11:0] alt_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic axis;
      logic prep;
      logic div_take;
      logic mul;
      logic sum;
      logic pos_start;
      logic pos_take;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic dead;
      logic ms_zero;
      logic div_done;
      logic az_move;
      logic out_busy;
   } stat_type;

endpackage

FILE: rtl/core/tsp_chan_if.sv
interface tsp_req_if #(parameter int SAMPLE_BITS = 10);
   logic valid;
   logic ready;
   logic [SAMPLE_BITS-1:0] sens_a;
   logic [SAMPLE_BITS-1:0] sens_b;
   logic [SAMPLE_BITS-1:0] sens_c;
   logic [SAMPLE_BITS-1:0] sens_d;
   logic [15:0] elapsed_ms;
   modport source (output valid, sens_a, sens_b, sens_c, sens_d, elapsed_ms, input ready);
   modport sink (input valid, sens_a, sens_b, sens_c, sens_d, elapsed_ms, output ready);
endinterface

interface tsp_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] light_status;
   logic signed [12:0] az_step;
   logic signed [12:0] alt_step;
   logic [11:0] az_pos;
   logic [11:0] alt_pos;
   modport source (output valid, light_status, az_step, alt_step, az_pos, alt_pos,
                   input ready);
   modport sink (input valid, light_status, az_step, alt_step, az_pos, alt_pos,
                 output ready);
endinterface

FILE: rtl/core/tsp_div.sv
module tsp_div #(
   parameter int DW = 27,
   parameter int VW = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [DW-1:0] dividend,
   input logic [VW-1:0] divisor,
   output logic done,
   output logic [DW-1:0] quo,
   output logic [VW-1:0] rem
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [VW:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // One quotient bit per cycle, restoring form.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = VW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
   assign rem = rem_ff;
endmodule

FILE: rtl/core/tsp_ctrl.sv
module tsp_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input tsp_pkg::stat_type stat,
   output tsp_pkg::cmd_type cmd
);
   import tsp_pkg::*;

   state_type state_ff, state_in;
   logic axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
               axis_in = 1'b0;
            end
         end
         ST_PREP: begin
            if (stat.dead) begin
               if (axis_ff) begin
                  state_in = ST_POS;
               end else begin
                  axis_in = 1'b1;
               end
            end else if (stat.ms_zero) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: begin
            if (axis_ff) begin
               state_in = ST_POS;
            end else begin
               axis_in = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_POS: state_in = stat.az_move ? ST_POSW : ST_FIN;
         ST_POSW: begin
            if (stat.div_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.axis = axis_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_PREP: cmd.prep = 1'b1;
         ST_DIV: cmd.div_take = stat.div_done;
         ST_MUL: cmd.mul = 1'b1;
         ST_SUM: cmd.sum = 1'b1;
         ST_POS: cmd.pos_start = stat.az_move;
         ST_POSW: cmd.pos_take = stat.div_done;
         ST_FIN: cmd.fin = !stat.out_busy;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: rtl/core/tsp_dp.sv
module tsp_dp #(
   parameter int SAMPLE_BITS = 10,
   parameter int INTEG_BITS = 24
) (
   input logic clock,
   input logic reset,
   input tsp_pkg::cfg_type cfg,
   input tsp_pkg::cmd_type cmd,
   output tsp_pkg::stat_type stat,
   input logic [SAMPLE_BITS-1:0] in_a,
   input logic [SAMPLE_BITS-1:0] in_b,
   input logic [SAMPLE_BITS-1:0] in_c,
   input logic [SAMPLE_BITS-1:0] in_d,
   input logic [15:0] in_ms,
   output logic out_valid,
   input logic out_ready,
   output logic [1:0] out_status,
   output logic signed [12:0] out_az_step,
   output logic signed [12:0] out_alt_step,
   output logic [11:0] out_az_pos,
   output logic [11:0] out_alt_pos
);
   import tsp_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int IB = INTEG_BITS;
   localparam int EW = SB + 1;
   localparam int DFW = SB + 2;
   localparam int PW = 17 + DFW;
   localparam int DW = 17 + SB;
   localparam int SW = 19 + IB;
   localparam int CW = (EW > 10) ? EW : 10;
   localparam int LW = (SB + 2 > 12) ? SB + 2 : 12;
   localparam int BW = (SB + 1 > 11) ? SB + 1 : 11;

   logic [SB-1:0] a_ff, b_ff, c_ff, d_ff;
   logic [15:0] ms_ff;
   logic signed [IB-1:0] az_int_ff, az_int_in, alt_int_ff, alt_int_in;
   logic signed [EW-1:0] az_prev_ff, az_prev_in, alt_prev_ff, alt_prev_in;
   logic [11:0] az_pos_ff, az_pos_in, alt_pos_ff, alt_pos_in;
   logic signed [DW:0] deriv_ff, deriv_in;
   logic dneg_ff, dneg_in, xneg_ff, xneg_in;
   logic signed [17+EW-1:0] p1_ff, p1_in;
   logic signed [17+IB-1:0] p2_ff, p2_in;
   logic signed [12:0] az_st_ff, az_st_in, alt_st_ff, alt_st_in;
   logic vld_ff, vld_in;
   logic [1:0] o_stat_ff, o_stat_in;
   logic signed [12:0] o_az_ff, o_az_in, o_alt_ff, o_alt_in;
   logic [11:0] o_azp_ff, o_azp_in, o_altp_ff, o_altp_in;

   logic [SB:0] s_ad, s_bc, s_cd, s_ab;
   logic [SB+1:0] s_all;
   logic signed [SB+1:0] side;
   logic [SB:0] side_mag;
   logic signed [EW-1:0] az_err, alt_err, err, prev;
   logic [EW-1:0] err_mag;
   logic signed [IB-1:0] integ;
   logic signed [IB:0] int_sum;
   logic signed [DFW-1:0] diff;
   logic signed [PW-1:0] prod;
   logic [PW-1:0] prod_mag;
   logic signed [SW-1:0] sum, sum_adj;
   logic signed [SW-Q_SHIFT-1:0] qv;
   logic signed [12:0] step;
   logic signed [13:0] az_x, alt_x, alt_np;
   logic [13:0] az_x_mag;
   logic [12:0] rev_eff, rem13;
   logic [12:0] az_np;
   logic [1:0] light;
   logic start;
   logic [DW-1:0] div_n, div_q;
   logic [15:0] div_v, div_r;
   logic div_done;

   tsp_div #(.DW(DW), .VW(16)) u_div (
      .clock(clock), .reset(reset), .start(start), .dividend(div_n),
      .divisor(div_v), .done(div_done), .quo(div_q), .rem(div_r)
   );

   always_comb begin
      s_ad = {1'b0, a_ff} + {1'b0, d_ff};
      s_bc = {1'b0, b_ff} + {1'b0, c_ff};
      s_cd = {1'b0, c_ff} + {1'b0, d_ff};
      s_ab = {1'b0, a_ff} + {1'b0, b_ff};
      s_all = {1'b0, s_ad} + {1'b0, s_bc};
      side = $signed({1'b0, s_ad}) - $signed({1'b0, s_bc});
      side_mag = side[SB+1] ? (SB+1)'(0) - side[SB:0] : side[SB:0];
      if (LW'(s_all) < LW'(cfg.low_light_level)) light = LIGHT_LOW;
      else if (BW'(side_mag) > BW'(cfg.balance_limit)) light = LIGHT_UNBAL;
      else light = LIGHT_BAL;

      // Pair averages are floored before the difference is taken.
      az_err = $signed({1'b0, s_bc[SB:1]}) - $signed({1'b0, s_ad[SB:1]});
      alt_err = $signed({1'b0, s_cd[SB:1]}) - $signed({1'b0, s_ab[SB:1]});
      err = cmd.axis ? alt_err : az_err;
      prev = cmd.axis ? alt_prev_ff : az_prev_ff;
      integ = cmd.axis ? alt_int_ff : az_int_ff;
      err_mag = err[EW-1] ? EW'(0) - EW'(err) : EW'(err);
      diff = DFW'(err) - DFW'(prev);
      prod = $signed({1'b0, cfg.gain_deriv}) * diff;
      prod_mag = prod[PW-1] ? PW'(0) - PW'(prod) : PW'(prod);

      int_sum = (IB+1)'(integ) + (IB+1)'(err);
      if (int_sum > (IB+1)'((64'sd1 <<< (IB-1)) - 1)) begin
         int_sum = (IB+1)'((64'sd1 <<< (IB-1)) - 1);
      end
      if (int_sum < -(IB+1)'(64'sd1 <<< (IB-1))) begin
         int_sum = -(IB+1)'(64'sd1 <<< (IB-1));
      end

      sum = SW'(p1_ff) + SW'(p2_ff) + SW'(deriv_ff);
      sum_adj = sum[SW-1] ? sum + SW'((1 << Q_SHIFT) - 1) : sum;
      qv = sum_adj[SW-1:Q_SHIFT];
      if (qv > (SW-Q_SHIFT)'(STEP_MAX)) step = 13'(STEP_MAX);
      else if (qv < -(SW-Q_SHIFT)'(STEP_MAX)) step = -13'(STEP_MAX);
      else step = 13'(qv);

      if (cfg.az_steps_rev == 13'd0) rev_eff = 13'd1;
      else if (cfg.az_steps_rev > 13'(REV_MAX)) rev_eff = 13'(REV_MAX);
      else rev_eff = cfg.az_steps_rev;
      az_x = $signed({2'b00, az_pos_ff}) + 14'(az_st_ff);
      az_x_mag = az_x[13] ? 14'd0 - az_x : az_x;
      rem13 = div_r[12:0];
      az_np = (xneg_ff && rem13 != 13'd0) ? rev_eff - rem13 : rem13;

      alt_x = $signed({2'b00, alt_pos_ff}) + 14'(alt_st_ff);
      alt_np = alt_x;
      if (alt_np > $signed({2'b00, cfg.alt_limit})) alt_np = $signed({2'b00, cfg.alt_limit});
      if (alt_np < 14'sd0) alt_np = 14'sd0;

      start = 1'b0;
      div_n = DW'(prod_mag);
      div_v = ms_ff;
      if (cmd.prep && err_mag > EW'(0) && CW'(err_mag) > CW'(cfg.error_deadband)
          && ms_ff != 16'd0) begin
         start = 1'b1;
      end
      if (cmd.pos_start) begin
         start = 1'b1;
         div_n = DW'(az_x_mag);
         div_v = {3'b000, rev_eff};
      end
   end

   always_comb begin
      az_int_in = az_int_ff;
      alt_int_in = alt_int_ff;
      az_prev_in = az_prev_ff;
      alt_prev_in = alt_prev_ff;
      az_pos_in = az_pos_ff;
      alt_pos_in = alt_pos_ff;
      deriv_in = deriv_ff;
      dneg_in = dneg_ff;
      xneg_in = xneg_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      az_st_in = az_st_ff;
      alt_st_in = alt_st_ff;
      vld_in = vld_ff && !out_ready;
      o_stat_in = o_stat_ff;
      o_az_in = o_az_ff;
      o_alt_in = o_alt_ff;
      o_azp_in = o_azp_ff;
      o_altp_in = o_altp_ff;
      if (cmd.prep) begin
         if (cmd.axis) alt_prev_in = err;
         else az_prev_in = err;
         deriv_in = '0;
         dneg_in = prod[PW-1];
         if (stat.dead) begin
            if (cmd.axis) alt_st_in = '0;
            else az_st_in = '0;
         end else if (cmd.axis) begin
            alt_int_in = IB'(int_sum);
         end else begin
            az_int_in = IB'(int_sum);
         end
      end
      if (cmd.div_take) begin
         deriv_in = dneg_ff ? (DW+1)'(0) - $signed({1'b0, div_q})
                            : $signed({1'b0, div_q});
      end
      if (cmd.mul) begin
         p1_in = $signed({1'b0, cfg.gain_prop}) * err;
         p2_in = $signed({1'b0, cfg.gain_integ}) * integ;
      end
      if (cmd.sum) begin
         if (cmd.axis) alt_st_in = step;
         else az_st_in = step;
      end
      if (cmd.pos_start) xneg_in = az_x[13];
      if (cmd.pos_take) az_pos_in = az_np[11:0];
      if (cmd.fin) begin
         vld_in = 1'b1;
         o_stat_in = light;
         o_az_in = az_st_ff;
         o_azp_in = az_pos_ff;
         if (alt_st_ff != 13'sd0) begin
            alt_pos_in = alt_np[11:0];
            o_alt_in = 13'(alt_np - $signed({2'b00, alt_pos_ff}));
            o_altp_in = alt_np[11:0];
         end else begin
            o_alt_in = '0;
            o_altp_in = alt_pos_ff;
         end
      end
   end

   always_comb begin
      stat.dead = !(CW'(err_mag) > CW'(cfg.error_deadband));
      stat.ms_zero = (ms_ff == 16'd0);
      stat.div_done = div_done;
      stat.az_move = (az_st_ff != 13'sd0);
      stat.out_busy = vld_ff && !out_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= in_a;
         b_ff <= in_b;
         c_ff <= in_c;
         d_ff <= in_d;
         ms_ff <= in_ms;
      end
      deriv_ff <= deriv_in;
      dneg_ff <= dneg_in;
      xneg_ff <= xneg_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      az_st_ff <= az_st_in;
      alt_st_ff <= alt_st_in;
      o_stat_ff <= o_stat_in;
      o_az_ff <= o_az_in;
      o_alt_ff <= o_alt_in;
      o_azp_ff <= o_azp_in;
      o_altp_ff <= o_altp_in;
      if (reset) begin
         az_int_ff <= '0;
         alt_int_ff <= '0;
         az_prev_ff <= '0;
         alt_prev_ff <= '0;
         az_pos_ff <= '0;
         alt_pos_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         az_int_ff <= az_int_in;
         alt_int_ff <= alt_int_in;
         az_prev_ff <= az_prev_in;
         alt_prev_ff <= alt_prev_in;
         az_pos_ff <= az_pos_in;
         alt_pos_ff <= alt_pos_in;
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_status = o_stat_ff;
   assign out_az_step = o_az_ff;
   assign out_alt_step = o_alt_ff;
   assign out_az_pos = o_azp_ff;
   assign out_alt_pos = o_altp_ff;
endmodule

FILE: rtl/core/quad_sensor_two_axis_pid_tracker.sv
// Channel    Port      Direction  Contents
// request    req_ch    in         sens_a..sens_d, elapsed_ms
// response   rsp_ch    out        light_status, az_step, alt_step, az_pos, alt_pos
// registers  csr_*     in/out     APB-style, eight registers at 4*i
//
// An item in which both axes sit in the deadband skips the divide, multiply and sum
// states. Each axis outside the deadband goes through the multiply and sum states, and
// through the shared restoring divider when elapsed_ms is not zero; an azimuth move
// uses the divider once more for the wrap.
// Reset is synchronous; it restores the register defaults and clears PID state.
// A result waits in the output register while the next item is accepted and worked.
module quad_sensor_two_axis_pid_tracker #(
   parameter int SAMPLE_BITS = 10,
   parameter int INTEG_BITS = 24
) (
   input logic clock,
   input logic reset,
   tsp_req_if.sink req_ch,
   tsp_rsp_if.source rsp_ch,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import tsp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   stat_type stat;
   logic [2:0] idx;

   assign idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_GAIN_PROP: cfg_in.gain_prop = csr_pwdata[15:0];
            REG_GAIN_INTEG: cfg_in.gain_integ = csr_pwdata[15:0];
            REG_GAIN_DERIV: cfg_in.gain_deriv = csr_pwdata[15:0];
            REG_DEADBAND: cfg_in.error_deadband = csr_pwdata[9:0];
            REG_LOW_LIGHT: cfg_in.low_light_level = csr_pwdata[11:0];
            REG_BAL_LIMIT: cfg_in.balance_limit = csr_pwdata[10:0];
            REG_AZ_REV: cfg_in.az_steps_rev = csr_pwdata[12:0];
            REG_ALT_LIMIT: cfg_in.alt_limit = csr_pwdata[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_GAIN_PROP: csr_prdata = {16'd0, cfg_ff.gain_prop};
         REG_GAIN_INTEG: csr_prdata = {16'd0, cfg_ff.gain_integ};
         REG_GAIN_DERIV: csr_prdata = {16'd0, cfg_ff.gain_deriv};
         REG_DEADBAND: csr_prdata = {22'd0, cfg_ff.error_deadband};
         REG_LOW_LIGHT: csr_prdata = {20'd0, cfg_ff.low_light_level};
         REG_BAL_LIMIT: csr_prdata = {21'd0, cfg_ff.balance_limit};
         REG_AZ_REV: csr_prdata = {19'd0, cfg_ff.az_steps_rev};
         REG_ALT_LIMIT: csr_prdata = {20'd0, cfg_ff.alt_limit};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop <= RST_GAIN_PROP;
         cfg_ff.gain_integ <= RST_GAIN_INTEG;
         cfg_ff.gain_deriv <= RST_GAIN_DERIV;
         cfg_ff.error_deadband <= RST_DEADBAND;
         cfg_ff.low_light_level <= RST_LOW_LIGHT;
         cfg_ff.balance_limit <= RST_BAL_LIMIT;
         cfg_ff.az_steps_rev <= RST_AZ_REV;
         cfg_ff.alt_limit <= RST_ALT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .stat(stat), .cmd(cmd)
   );

   tsp_dp #(.SAMPLE_BITS(SAMPLE_BITS), .INTEG_BITS(INTEG_BITS)) u_dp (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd(cmd), .stat(stat),
      .in_a(req_ch.sens_a), .in_b(req_ch.sens_b), .in_c(req_ch.sens_c),
      .in_d(req_ch.sens_d), .in_ms(req_ch.elapsed_ms),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
      .out_status(rsp_ch.light_status), .out_az_step(rsp_ch.az_step),
      .out_alt_step(rsp_ch.alt_step), .out_az_pos(rsp_ch.az_pos),
      .out_alt_pos(rsp_ch.alt_pos)
   );
endmodule
